FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the vertex unit cube normalizer.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, held off while reset is high.
`define VUCN_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define VUCN_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/vucn_pkg.sv
// Types and constants of the vertex unit cube normalizer.
// Depends on nothing; used by vucn_div, vertex_unit_cube_normalizer and the testbench.
package vucn_pkg;

   localparam int COORD_W   = 32;   // Q16.16 coordinate
   localparam int NORM_W    = 17;   // Q.16 normalized result
   localparam int DIFF_W    = 33;   // point minus centre
   localparam int QUO_BITS  = 17;   // quotient bits developed by the divider
   localparam int REM_W     = 51;   // dividend and partial remainder
   localparam int STEP_W    = 5;    // divider step counter
   localparam logic [NORM_W-1:0] NORM_MAX = 17'd32768;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_BOX,
      ST_READ,
      ST_START,
      ST_DIV
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_PREP,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

FILE: rtl/vertex_unit_cube_normalizer.sv
// Vertex unit cube normalizer: loads points, then emits them centred and scaled to the box.
// A point word is stored, while there is room, at the edge that accepts it; the word marked
// last closes the set, after which each stored point is read, divided and strobed in turn.
// Throughput while loading: one point word per cycle; busy is high during emission.
// Reset (synchronous, active high) empties the set; the point store holds no reset value.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`include "assert_macros.svh"

module vertex_unit_cube_normalizer import vucn_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_px,
   input  logic signed [COORD_W-1:0] req_py,
   input  logic signed [COORD_W-1:0] req_pz,
   input  logic                      req_is_last,
   output logic                      rsp_valid,
   output logic signed [NORM_W-1:0]  rsp_nx,
   output logic signed [NORM_W-1:0]  rsp_ny,
   output logic signed [NORM_W-1:0]  rsp_nz,
   output logic [COORD_W-1:0]        rsp_extent_x,
   output logic [COORD_W-1:0]        rsp_extent_y,
   output logic [COORD_W-1:0]        rsp_extent_z,
   output logic signed [COORD_W-1:0] rsp_centre_x,
   output logic signed [COORD_W-1:0] rsp_centre_y,
   output logic signed [COORD_W-1:0] rsp_centre_z,
   output logic                      rsp_dropped,
   output logic                      rsp_end_of_set
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   // Point store: one memory per axis, written while loading, read back while emitting.
   // Loading and emission never overlap, so busy alone keeps the accesses apart.
   logic [COORD_W-1:0] mem_x [MAX_POINTS];
   logic [COORD_W-1:0] mem_y [MAX_POINTS];
   logic [COORD_W-1:0] mem_z [MAX_POINTS];
   logic [COORD_W-1:0] rd_x_ff, rd_y_ff, rd_z_ff;

   ctrl_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic signed [COORD_W-1:0] lo_ff [3];
   logic signed [COORD_W-1:0] hi_ff [3];
   logic signed [COORD_W-1:0] lo_in [3];
   logic signed [COORD_W-1:0] hi_in [3];
   logic [COORD_W-1:0]        ext_ff [3];
   logic signed [COORD_W-1:0] cen_ff [3];
   logic signed [COORD_W-1:0] pin [3];

   logic accept, room, wr_en, first, div_start, div_done;
   logic [2:0] done_vec;
   logic signed [DIFF_W-1:0] diff [3];
   logic signed [NORM_W-1:0] quot [3];
   logic [COORD_W-1:0] rd_vec [3];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [NORM_W-1:0]  rsp_n_ff [3];
   logic [COORD_W-1:0]        rsp_ext_ff [3];
   logic signed [COORD_W-1:0] rsp_cen_ff [3];
   logic                      rsp_drop_ff, rsp_end_ff, is_end;

   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && !busy;
   assign room   = (count_ff < CW'(MAX_POINTS));
   assign wr_en  = accept && room;
   assign first  = (count_ff == '0);
   assign pin[0] = req_px;
   assign pin[1] = req_py;
   assign pin[2] = req_pz;
   assign is_end = ((CW'(idx_ff) + CW'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[count_ff[AW-1:0]] <= req_px;
         mem_y[count_ff[AW-1:0]] <= req_py;
         mem_z[count_ff[AW-1:0]] <= req_pz;
      end
      rd_x_ff <= mem_x[idx_ff];
      rd_y_ff <= mem_y[idx_ff];
      rd_z_ff <= mem_z[idx_ff];
   end

   // Running bounding box; the first stored point of a set seeds both corners.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lo_in[a] = lo_ff[a];
         hi_in[a] = hi_ff[a];
         if (wr_en && (first || (pin[a] < lo_ff[a]))) begin
            lo_in[a] = pin[a];
         end
         if (wr_en && (first || (pin[a] > hi_ff[a]))) begin
            hi_in[a] = pin[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         lo_ff[a] <= lo_in[a];
         hi_ff[a] <= hi_in[a];
         if (state_ff == ST_BOX) begin
            ext_ff[a] <= COORD_W'(hi_ff[a] - lo_ff[a]);
            // Arithmetic shift of the 33-bit sum rounds the centre toward minus infinity.
            cen_ff[a] <= COORD_W'((DIFF_W'(hi_ff[a]) + DIFF_W'(lo_ff[a])) >>> 1);
         end
      end
   end

   // Control: load, form the box, then read, divide and emit each stored point.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_last) begin
                  state_in = ST_BOX;
               end
            end
         end
         ST_BOX: begin
            idx_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               if (is_end) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rd_vec[0] = rd_x_ff;
   assign rd_vec[1] = rd_y_ff;
   assign rd_vec[2] = rd_z_ff;

   // One divider per axis; all three run in lock step.
   for (genvar a = 0; a < 3; a++) begin : g_axis
      assign diff[a] = DIFF_W'(signed'(rd_vec[a])) - DIFF_W'(cen_ff[a]);
      vucn_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .diff  (diff[a]),
         .ext   (ext_ff[a]),
         .done  (done_vec[a]),
         .quot  (quot[a])
      );
   end
   assign div_done = &done_vec;

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV) && div_done) begin
         for (int a = 0; a < 3; a++) begin
            rsp_n_ff[a]   <= quot[a];
            rsp_ext_ff[a] <= ext_ff[a];
            rsp_cen_ff[a] <= cen_ff[a];
         end
         rsp_drop_ff <= ovf_ff;
         rsp_end_ff  <= is_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_nx         = rsp_n_ff[0];
   assign rsp_ny         = rsp_n_ff[1];
   assign rsp_nz         = rsp_n_ff[2];
   assign rsp_extent_x   = rsp_ext_ff[0];
   assign rsp_extent_y   = rsp_ext_ff[1];
   assign rsp_extent_z   = rsp_ext_ff[2];
   assign rsp_centre_x   = rsp_cen_ff[0];
   assign rsp_centre_y   = rsp_cen_ff[1];
   assign rsp_centre_z   = rsp_cen_ff[2];
   assign rsp_dropped    = rsp_drop_ff;
   assign rsp_end_of_set = rsp_end_ff;

   `VUCN_ASSERT(a_rsp_spaced, clock, reset, rsp_valid |=> !rsp_valid, "result words back to back")
   `VUCN_ASSERT(a_count_cap, clock, reset, count_ff <= CW'(MAX_POINTS), "point count over capacity")
   `VUCN_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid), "not idle after reset")
   `VUCN_ASSERT(a_end_frees, clock, reset, (rsp_valid && rsp_end_of_set) |-> !busy, "busy after end")
   `VUCN_ASSERT(a_last_busy, clock, reset, (accept && req_is_last) |=> busy, "last word not closing set")

endmodule

FILE: rtl/vucn_div.sv
// Sequential rounding divider: round(|d| * 65536 / ext), saturated, with the sign of d.
// Depends on vucn_pkg.
module vucn_div import vucn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [DIFF_W-1:0]  diff,
   input  logic [COORD_W-1:0]        ext,
   output logic                      done,
   output logic signed [NORM_W-1:0]  quot
);

   div_state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               neg_ff, neg_in;
   logic [DIFF_W-1:0]  mag_ff, mag_in;
   logic [COORD_W-1:0] div_ff, div_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [REM_W-1:0]   dsh_ff, dsh_in;
   logic [QUO_BITS-1:0] q_ff, q_in;
   logic               sat_ff, sat_in;
   logic [REM_W-1:0]   numer;
   logic [REM_W-1:0]   dtop;
   logic [NORM_W-1:0]  qmag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   // Rounded quotient is floor((2*mag*65536 + div) / (2*div)).
   assign numer = {1'b0, mag_ff, 17'd0} + REM_W'(div_ff);
   assign dtop  = {1'b0, div_ff, 18'd0};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      sat_in   = sat_ff;
      done     = 1'b0;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               neg_in   = diff[DIFF_W-1];
               mag_in   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
               div_in   = (ext == '0) ? COORD_W'(1) : ext;
               state_in = DIV_PREP;
            end
         end
         DIV_PREP: begin
            rem_in   = numer;
            dsh_in   = {18'd0, div_ff, 1'b0} << (QUO_BITS - 1);
            sat_in   = (numer >= dtop);
            q_in     = '0;
            step_in  = '0;
            state_in = DIV_RUN;
         end
         DIV_RUN: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[QUO_BITS-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[QUO_BITS-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUO_BITS - 1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            done     = 1'b1;
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   assign qmag = (sat_ff || (q_ff > NORM_MAX)) ? NORM_MAX : q_ff;
   assign quot = neg_ff ? NORM_W'(-qmag) : NORM_W'(qmag);

endmodule

FILE: bench/vertex_unit_cube_normalizer_test.sv
// Self-checking testbench for the vertex unit cube normalizer.
// Depends on vucn_pkg and vertex_unit_cube_normalizer; stands alone otherwise.
module vertex_unit_cube_normalizer_test;
   import vucn_pkg::*;

   localparam int SET_CAP     = 64;
   localparam int ITEM_GOAL   = 460;
   localparam int QUIET_TAIL  = 60;     // words at the end sent without idle gaps
   localparam int STALL_LIMIT = 4000;   // cycles in which no word moves on either side
   localparam int DRAIN_WAIT  = 60;

   // One point word as the sender presents it.
   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
   } point_word_type;

   // One normalized word as the block should emit it.
   typedef struct {
      logic signed [NORM_W-1:0]  nx, ny, nz;
      logic [COORD_W-1:0]        ext_x, ext_y, ext_z;
      logic signed [COORD_W-1:0] cen_x, cen_y, cen_z;
      logic                      dropped;
      logic                      end_of_set;
   } norm_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0] req_px = '0, req_py = '0, req_pz = '0;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic signed [NORM_W-1:0] rsp_nx, rsp_ny, rsp_nz;
   logic [COORD_W-1:0] rsp_extent_x, rsp_extent_y, rsp_extent_z;
   logic signed [COORD_W-1:0] rsp_centre_x, rsp_centre_y, rsp_centre_z;
   logic rsp_dropped, rsp_end_of_set;

   vertex_unit_cube_normalizer u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_px(req_px), .req_py(req_py), .req_pz(req_pz), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_nx(rsp_nx), .rsp_ny(rsp_ny), .rsp_nz(rsp_nz),
      .rsp_extent_x(rsp_extent_x), .rsp_extent_y(rsp_extent_y),
      .rsp_extent_z(rsp_extent_z), .rsp_centre_x(rsp_centre_x),
      .rsp_centre_y(rsp_centre_y), .rsp_centre_z(rsp_centre_z),
      .rsp_dropped(rsp_dropped), .rsp_end_of_set(rsp_end_of_set)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   point_word_type pending_points[$];     // words not yet offered to the block
   norm_word_type  expected_norms[$];     // normalized words still owed by the block
   point_word_type offered;               // word currently on the request ports
   int          idle_left = 0;
   int          error_count = 0;
   int          quiet_cycles = 0;
   bit          word_moved;

   // Shadow copy of the block's set: the stored points, the running box and
   // the drop flag. Only entries below set_size are ever read back.
   logic signed [COORD_W-1:0] set_pts[3][SET_CAP];
   longint box_lo[3], box_hi[3];
   int     set_size = 0;
   bit     set_overflow = 1'b0;

   // Rounds (v - centre) * 2^16 / extent to nearest, ties away from zero,
   // with a zero extent taken as one and the magnitude clipped to one half.
   function automatic logic signed [NORM_W-1:0] scale_to_box(longint v, longint c,
                                                            longint unsigned ext);
      longint d;
      longint unsigned mag, div, q;
      d   = v - c;
      mag = (d < 0 ? -d : d) << 16;
      div = (ext == 0) ? 1 : ext;
      q   = (2 * mag + div) / (2 * div);
      if (q > 32768) q = 32768;
      return (d < 0) ? NORM_W'(-$signed({1'b0, q[NORM_W-1:0]}))
                     : NORM_W'($signed({1'b0, q[NORM_W-1:0]}));
   endfunction

   // Adds one accepted point word to the shadow set and, when it closes the
   // set, queues the whole set of normalized words.
   task automatic absorb_point(point_word_type w);
      longint p[3];
      longint unsigned ext[3];
      longint cen[3];
      norm_word_type r;
      p[0] = w.x; p[1] = w.y; p[2] = w.z;
      if (set_size < SET_CAP) begin
         for (int a = 0; a < 3; a++) begin
            set_pts[a][set_size] = p[a][COORD_W-1:0];
            if (set_size == 0 || p[a] < box_lo[a]) box_lo[a] = p[a];
            if (set_size == 0 || p[a] > box_hi[a]) box_hi[a] = p[a];
         end
         set_size++;
      end else begin
         set_overflow = 1'b1;
      end
      if (!w.last) return;
      for (int a = 0; a < 3; a++) begin
         ext[a] = box_hi[a] - box_lo[a];
         cen[a] = (box_hi[a] + box_lo[a]) >>> 1;   // floor of the half sum
      end
      for (int k = 0; k < set_size; k++) begin
         r.nx = scale_to_box(set_pts[0][k], cen[0], ext[0]);
         r.ny = scale_to_box(set_pts[1][k], cen[1], ext[1]);
         r.nz = scale_to_box(set_pts[2][k], cen[2], ext[2]);
         r.ext_x = ext[0][31:0]; r.ext_y = ext[1][31:0]; r.ext_z = ext[2][31:0];
         r.cen_x = cen[0][31:0]; r.cen_y = cen[1][31:0]; r.cen_z = cen[2][31:0];
         r.dropped    = set_overflow;
         r.end_of_set = (k + 1 == set_size);
         expected_norms.push_back(r);
      end
      set_size     = 0;
      set_overflow = 1'b0;
   endtask

   // Driver. A word moves at an edge where start is high and busy is low.
   // The next word, or an idle gap, is chosen only once the slot is free.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) absorb_point(offered);
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_points.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(0, 12);
            start <= 1'b0;
         end else if (pending_points.size() > 0) begin
            offered = pending_points.pop_front();
            req_px      <= offered.x;
            req_py      <= offered.y;
            req_pz      <= offered.z;
            req_is_last <= offered.last;
            start       <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, longint exp_v, longint act_v, bit differs);
      if (differs) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Monitor. Every strobed word is checked against the oldest expectation.
   always @(posedge clock) begin
      norm_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_norms.size() == 0) begin
            $error("normalized word with nothing expected");
            error_count++;
         end else begin
            e = expected_norms.pop_front();
            check_field("nx", e.nx, rsp_nx, rsp_nx !== e.nx);
            check_field("ny", e.ny, rsp_ny, rsp_ny !== e.ny);
            check_field("nz", e.nz, rsp_nz, rsp_nz !== e.nz);
            check_field("extent_x", e.ext_x, rsp_extent_x, rsp_extent_x !== e.ext_x);
            check_field("extent_y", e.ext_y, rsp_extent_y, rsp_extent_y !== e.ext_y);
            check_field("extent_z", e.ext_z, rsp_extent_z, rsp_extent_z !== e.ext_z);
            check_field("centre_x", e.cen_x, rsp_centre_x, rsp_centre_x !== e.cen_x);
            check_field("centre_y", e.cen_y, rsp_centre_y, rsp_centre_y !== e.cen_y);
            check_field("centre_z", e.cen_z, rsp_centre_z, rsp_centre_z !== e.cen_z);
            check_field("dropped", e.dropped, rsp_dropped, rsp_dropped !== e.dropped);
            check_field("end_of_set", e.end_of_set, rsp_end_of_set,
                        rsp_end_of_set !== e.end_of_set);
         end
      end
   end

   // Watchdog. A cycle in which no word moves on either side counts as quiet.
   always @(posedge clock) begin
      word_moved = (start && !busy) || rsp_valid;
      if (reset || word_moved) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic point_word_type make_word(logic signed [COORD_W-1:0] x,
                                                logic signed [COORD_W-1:0] y,
                                                logic signed [COORD_W-1:0] z, bit last);
      point_word_type w;
      w.x = x; w.y = y; w.z = z; w.last = last;
      return w;
   endfunction

   // Coordinates span the whole range, cluster tightly or loosely around a base or
   // sit near either extreme, so that tiny extents, ties and clipping show up as well.
   function automatic logic signed [COORD_W-1:0] pick_coord(int spread,
                                                           logic signed [COORD_W-1:0] base);
      case (spread)
         0: return $urandom;
         1: return base + $signed($urandom_range(0, 3));
         2: return base + $signed($urandom_range(0, 1 << 20));
         default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 5)
                                              : 32'sh80000000 + $urandom_range(0, 5);
      endcase
   endfunction

   initial begin
      int words, n, spread;
      logic signed [COORD_W-1:0] bx, by, bz;

      // A lone point at the most negative corner: zero extent on every axis.
      pending_points.push_back(make_word(32'sh80000000, 32'sh80000000, 32'sh80000000, 1));
      // A lone point at the most positive corner.
      pending_points.push_back(make_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1));
      // The widest box the coordinates allow, with a middle value on each axis.
      pending_points.push_back(make_word(32'sh80000000, 32'sh7fffffff, 32'sh00000000, 0));
      pending_points.push_back(make_word(32'sh00000000, 32'sh00000000, 32'sh80000000, 0));
      pending_points.push_back(make_word(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1));
      // Extent of one LSB: the farthest points clip to plus one half.
      pending_points.push_back(make_word(32'sd0, -32'sd1, 32'sd5, 0));
      pending_points.push_back(make_word(32'sd1, 32'sd0, 32'sd6, 0));
      pending_points.push_back(make_word(32'sd1, -32'sd1, 32'sd5, 1));
      // Small extents around zero, one with an odd sum of corners so that the halved centre rounds down.
      pending_points.push_back(make_word(-32'sd2, 32'sd3, -32'sd7, 0));
      pending_points.push_back(make_word(32'sd1, -32'sd3, 32'sd0, 0));
      pending_points.push_back(make_word(32'sd0, 32'sd0, -32'sd2, 0));
      pending_points.push_back(make_word(-32'sd1, 32'sd1, 32'sd1, 1));
      // Ordinary Q16.16 values with one zero-extent axis.
      pending_points.push_back(make_word(32'sh00010000, 32'sh00030000, -32'sh00020000, 0));
      pending_points.push_back(make_word(32'sh00028000, 32'sh00030000, 32'sh00020000, 1));
      words = pending_points.size();

      // Random sets: mostly a few points, now and then one near or past capacity so
      // that words are dropped, sometimes with the closing word dropped too.
      while (words < ITEM_GOAL) begin
         n = ($urandom_range(0, 24) == 0) ? $urandom_range(SET_CAP - 2, SET_CAP + 6)
                                          : $urandom_range(1, 9);
         spread = $urandom_range(0, 3);
         bx = $urandom; by = $urandom; bz = $urandom;
         for (int i = 0; i < n; i++) begin
            pending_points.push_back(make_word(pick_coord(spread, bx), pick_coord(spread, by),
                                               pick_coord(spread, bz), i == n - 1));
         end
         words += n;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_points.size() > 0 || start || expected_norms.size() > 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0 && expected_norms.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/vucn_pkg.sv
rtl/vucn_div.sv
rtl/vertex_unit_cube_normalizer.sv
bench/vertex_unit_cube_normalizer_test.sv
